@@ src/json_utf8_byte_validator_top_macros.svh @@
// ----------------------------------------------------------------------------
// JSON UTF-8 byte validator assertion macros
// Shorthand for the concurrent checks on the validator's ports.
// ----------------------------------------------------------------------------
`ifndef JSON_UTF8_BYTE_VALIDATOR_TOP_MACROS_SVH
`define JSON_UTF8_BYTE_VALIDATOR_TOP_MACROS_SVH

// check outside reset only
`define JUBV_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check at every edge, reset included
`define JUBV_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/jubv_pkg.sv @@
// ----------------------------------------------------------------------------
// JSON UTF-8 byte validator package
// Byte class record passed from front to back, and code point limits.
// ----------------------------------------------------------------------------
package jubv_pkg;

	localparam int unsigned CP_W = 21;

	localparam logic [CP_W-1:0] CP_MIN_2   = 21'h00080;
	localparam logic [CP_W-1:0] CP_MIN_3   = 21'h00800;
	localparam logic [CP_W-1:0] CP_MIN_4   = 21'h10000;
	localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO    = 21'h0D800;
	localparam logic [CP_W-1:0] SURR_HI    = 21'h0DFFF;

	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// one classified byte
	typedef struct packed {
		logic       last;
		logic       ctrl;       // below 0x20
		logic       ctrl_ok;    // tab, LF or CR
		logic       ascii;      // 0x20 to 0x7F
		logic       quote;
		logic       bslash;
		logic       tail;       // 10xxxxxx
		logic [1:0] lead_tails; // tails a lead byte announces, 0 if not a lead
		logic [5:0] bits;       // payload bits of a lead or a tail
	} class_t;

	function automatic logic [CP_W-1:0] min_cp(input logic [1:0] seq_len);
		logic [CP_W-1:0] m;
		case (seq_len)
			2'd1:    m = CP_MIN_2;
			2'd2:    m = CP_MIN_3;
			default: m = CP_MIN_4;
		endcase
		return m;
	endfunction

endpackage

@@ src/jubv_front.sv @@
// ----------------------------------------------------------------------------
// JSON UTF-8 byte validator front
// Accepts bytes, classifies them and queues the class records.
// ----------------------------------------------------------------------------
module jubv_front #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        byte_value,
	input  logic              last_byte,
	output logic              item_valid,
	output jubv_pkg::class_t  item,
	input  logic              item_pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	jubv_pkg::class_t cls;
	jubv_pkg::class_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;

	always_comb begin
		cls            = '0;
		cls.last       = last_byte;
		cls.ctrl       = (byte_value[7:5] == 3'b000);
		cls.ctrl_ok    = (byte_value == jubv_pkg::CH_TAB) || (byte_value == jubv_pkg::CH_LF)
			|| (byte_value == jubv_pkg::CH_CR);
		cls.ascii      = !byte_value[7] && !cls.ctrl;
		cls.quote      = (byte_value == jubv_pkg::CH_QUOTE);
		cls.bslash     = (byte_value == jubv_pkg::CH_BSLASH);
		cls.tail       = (byte_value[7:6] == 2'b10);
		cls.bits       = byte_value[5:0];
		if (byte_value >= jubv_pkg::LEAD2_LO && byte_value <= jubv_pkg::LEAD2_HI) begin
			cls.lead_tails = 2'd1;
			cls.bits       = {1'b0, byte_value[4:0]};
		end else if (byte_value >= jubv_pkg::LEAD3_LO && byte_value <= jubv_pkg::LEAD3_HI) begin
			cls.lead_tails = 2'd2;
			cls.bits       = {2'b00, byte_value[3:0]};
		end else if (byte_value >= jubv_pkg::LEAD4_LO && byte_value <= jubv_pkg::LEAD4_HI) begin
			cls.lead_tails = 2'd3;
			cls.bits       = {3'b000, byte_value[2:0]};
		end
	end

	assign in_ready   = (count_q != CNT_W'(DEPTH));
	assign push       = in_valid && in_ready;
	assign item_valid = (count_q != '0);
	assign item       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (item_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, item_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/jubv_back.sv @@
// ----------------------------------------------------------------------------
// JSON UTF-8 byte validator back
// Applies classified bytes to the message state and holds the verdict.
// ----------------------------------------------------------------------------
module jubv_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  jubv_pkg::class_t  item,
	output logic              item_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              message_valid
);

	localparam int unsigned CP_W = jubv_pkg::CP_W;

	logic            in_str_q, esc_q, err_q;
	logic [1:0]      tails_q, seq_q;
	logic [CP_W-1:0] cp_q;
	logic            out_valid_q, verdict_q;

	logic            in_str_d, esc_d, err_d;
	logic [1:0]      tails_d, seq_d;
	logic [CP_W-1:0] cp_d, cp_cat;

	// a last byte needs room in the output register
	assign item_pop = item_valid && (!item.last || !out_valid_q || out_ready);
	assign cp_cat   = {cp_q[CP_W-7:0], item.bits};

	always_comb begin
		in_str_d = in_str_q;
		esc_d    = esc_q;
		err_d    = err_q;
		tails_d  = tails_q;
		seq_d    = seq_q;
		cp_d     = cp_q;
		if (!err_q) begin
			if (tails_q != 2'd0) begin
				if (!item.tail) begin
					err_d = 1'b1;
				end else begin
					cp_d    = cp_cat;
					tails_d = tails_q - 2'd1;
					if (tails_q == 2'd1) begin
						// sequence complete: reject overlong, out of range and surrogates
						if (cp_cat < jubv_pkg::min_cp(seq_q) || cp_cat > jubv_pkg::CP_MAX
							|| (cp_cat >= jubv_pkg::SURR_LO && cp_cat <= jubv_pkg::SURR_HI)) begin
							err_d = 1'b1;
						end
						cp_d  = '0;
						seq_d = 2'd0;
					end
				end
			end else if (item.ctrl) begin
				if (in_str_q || !item.ctrl_ok) begin
					err_d = 1'b1;
				end
			end else if (item.ascii) begin
				if (in_str_q) begin
					if (esc_q) begin
						esc_d = 1'b0;
					end else if (item.bslash) begin
						esc_d = 1'b1;
					end else if (item.quote) begin
						in_str_d = 1'b0;
					end
				end else if (item.quote) begin
					in_str_d = 1'b1;
				end
			end else if (item.lead_tails != 2'd0) begin
				tails_d = item.lead_tails;
				seq_d   = item.lead_tails;
				cp_d    = CP_W'(item.bits);
			end else begin
				err_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_str_q    <= 1'b0;
			esc_q       <= 1'b0;
			err_q       <= 1'b0;
			tails_q     <= 2'd0;
			seq_q       <= 2'd0;
			cp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_pop && item.last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (item_pop) begin
				if (item.last) begin
					// judge, then clear for the next message
					in_str_q    <= 1'b0;
					esc_q       <= 1'b0;
					err_q       <= 1'b0;
					tails_q     <= 2'd0;
					seq_q       <= 2'd0;
					cp_q        <= '0;
				end else begin
					in_str_q <= in_str_d;
					esc_q    <= esc_d;
					err_q    <= err_d;
					tails_q  <= tails_d;
					seq_q    <= seq_d;
					cp_q     <= cp_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop && item.last) begin
			verdict_q <= !err_d && (tails_d == 2'd0);
		end
	end

	assign out_valid     = out_valid_q;
	assign message_valid = verdict_q;

endmodule

@@ src/json_utf8_byte_validator_top.sv @@
// ----------------------------------------------------------------------------
// JSON UTF-8 byte validator
// Checks a message byte by byte for strict UTF-8 and JSON control rules.
// ----------------------------------------------------------------------------
//  channel  direction  payload                 handshake
//  in       sink       byte_value, last_byte   in_valid / in_ready
//  out      source     message_valid           out_valid / out_ready
//
//  One byte per cycle while the queue has room and a last byte finds the
//  output register free or being read. The last byte is queued, then judged
//  into the output register, which raises out_valid. The front queue
//  (QUEUE_DEPTH entries) absorbs output stalls; in_ready drops only when it
//  is full. Reset is asynchronous and clears the control state, not the verdict.
// ----------------------------------------------------------------------------
module json_utf8_byte_validator_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_value,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       message_valid
);

	jubv_pkg::class_t item;
	logic             item_valid;
	logic             item_pop;

	jubv_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	jubv_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item          (item),
		.item_pop      (item_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.message_valid (message_valid)
	);

endmodule

@@ src/jubv_checker.sv @@
// ----------------------------------------------------------------------------
// JSON UTF-8 byte validator checker
// Port-level checks on reset behaviour and on both channels.
// ----------------------------------------------------------------------------
`include "json_utf8_byte_validator_top_macros.svh"

module jubv_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] byte_value,
	input logic       last_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic       message_valid
);

	`JUBV_ASSERT_RST(a_no_result_in_reset, !arst_n |-> !out_valid, "result shown during reset")
	`JUBV_ASSERT_RST(a_ready_after_reset, $rose(arst_n) |-> (in_ready && !out_valid), "not empty after reset")
	`JUBV_ASSERT_CLK(a_result_held, (out_valid && !out_ready) |=> (out_valid && $stable(message_valid)), "stalled result changed")
	`JUBV_ASSERT_CLK(a_input_held, (in_valid && !in_ready) |=> (in_valid && $stable(byte_value) && $stable(last_byte)), "waiting transaction changed")

endmodule

bind json_utf8_byte_validator_top jubv_checker u_jubv_checker (.*);

@@ bench/json_utf8_byte_validator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON UTF-8 byte validator checker
// Watches both channels and keeps its own copy of the string, escape and
// UTF-8 sequence state. Each accepted last byte queues a predicted verdict.
// Each accepted verdict is checked against the oldest one in the queue.
// ----------------------------------------------------------------------------
module json_utf8_byte_validator_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] byte_value,
	input  logic       last_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       message_valid,
	output int         verdicts_owed,
	output int         fail_count
);

	logic                      in_str;
	logic                      esc_pend;
	logic [1:0]                tails_left;
	logic [1:0]                seq_tails;
	logic [jubv_pkg::CP_W-1:0] cp_acc;
	logic                      err_flag;

	logic            verdicts_due[$];

	task automatic restart_scan();
		in_str     = 1'b0;
		esc_pend   = 1'b0;
		tails_left = 2'd0;
		seq_tails  = 2'd0;
		cp_acc     = '0;
		err_flag   = 1'b0;
	endtask

	// advance the scan by one byte; nothing changes once an error is seen
	task automatic absorb_byte(input logic [7:0] b);
		logic [jubv_pkg::CP_W-1:0] cp;
		logic [jubv_pkg::CP_W-1:0] floor_cp;
		if (!err_flag) begin
			if (tails_left != 2'd0) begin
				if (b[7:6] != 2'b10) begin
					err_flag = 1'b1;
				end else begin
					cp = {cp_acc[jubv_pkg::CP_W-7:0], b[5:0]};
					tails_left = tails_left - 2'd1;
					if (tails_left == 2'd0) begin
						floor_cp = (seq_tails == 2'd1) ? jubv_pkg::CP_MIN_2 :
							(seq_tails == 2'd2) ? jubv_pkg::CP_MIN_3 : jubv_pkg::CP_MIN_4;
						// reject overlong forms, values past the top and surrogates
						if (cp < floor_cp || cp > jubv_pkg::CP_MAX
							|| (cp >= jubv_pkg::SURR_LO && cp <= jubv_pkg::SURR_HI))
							err_flag = 1'b1;
						cp = '0;
						seq_tails = 2'd0;
					end
					cp_acc = cp;
				end
			end else if (b < 8'h20) begin
				if (in_str || !(b == jubv_pkg::CH_TAB || b == jubv_pkg::CH_LF
					|| b == jubv_pkg::CH_CR))
					err_flag = 1'b1;
			end else if (b < 8'h80) begin
				if (in_str) begin
					if (esc_pend)
						esc_pend = 1'b0;
					else if (b == jubv_pkg::CH_BSLASH)
						esc_pend = 1'b1;
					else if (b == jubv_pkg::CH_QUOTE)
						in_str = 1'b0;
				end else if (b == jubv_pkg::CH_QUOTE) begin
					in_str = 1'b1;
				end
			end else if (b >= jubv_pkg::LEAD2_LO && b <= jubv_pkg::LEAD2_HI) begin
				tails_left = 2'd1;
				seq_tails  = 2'd1;
				cp_acc     = jubv_pkg::CP_W'(b[4:0]);
			end else if (b >= jubv_pkg::LEAD3_LO && b <= jubv_pkg::LEAD3_HI) begin
				tails_left = 2'd2;
				seq_tails  = 2'd2;
				cp_acc     = jubv_pkg::CP_W'(b[3:0]);
			end else if (b >= jubv_pkg::LEAD4_LO && b <= jubv_pkg::LEAD4_HI) begin
				tails_left = 2'd3;
				seq_tails  = 2'd3;
				cp_acc     = jubv_pkg::CP_W'(b[2:0]);
			end else begin
				err_flag = 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			restart_scan();
			verdicts_due.delete();
			verdicts_owed = 0;
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t: unexpected verdict: expected none, got %0b",
						$time, message_valid);
					fail_count++;
				end else begin
					want = verdicts_due.pop_front();
					if (message_valid !== want) begin
						$display("%0t: message_valid mismatch: expected %0b, got %0b",
							$time, want, message_valid);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				absorb_byte(byte_value);
				if (last_byte) begin
					// a sequence cut short by the end of the message fails too
					verdicts_due.push_back(!err_flag && tails_left == 2'd0);
					restart_scan();
				end
			end
			verdicts_owed = verdicts_due.size();
		end
	end

endmodule

@@ bench/json_utf8_byte_validator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON UTF-8 byte validator testbench
// Sends directed messages, then random ones: well-formed JSON-like text with
// strings, escapes and UTF-8 characters, the same with one fault planted,
// and raw noise. Sender gaps and receiver stalls vary by phase; the checker
// beside the block predicts and compares every verdict.
// ----------------------------------------------------------------------------
module json_utf8_byte_validator_top_tb;

	localparam int CYCLE_LIMIT = 400000;

	logic       clk;
	logic       arst_n     = 1'b1;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic [7:0] byte_value = 8'h00;
	logic       last_byte  = 1'b0;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic       message_valid;

	int         verdicts_owed;
	int         fail_count;
	int         idle_pct   = 0;
	int         stall_pct  = 0;
	int         bytes_sent = 0;
	int         cycle_count = 0;

	logic [7:0] msg_bytes[$];

	json_utf8_byte_validator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_value   (byte_value),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.message_valid(message_valid)
	);

	json_utf8_byte_validator_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_value   (byte_value),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.message_valid(message_valid),
		.verdicts_owed(verdicts_owed),
		.fail_count   (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("json_utf8_byte_validator_top verification failed");
			$finish;
		end
	end

	// encode a scalar value in nb bytes, overlong or out of range if so chosen
	function automatic void put_utf8(input logic [20:0] cp, input int nb);
		case (nb)
			2:       msg_bytes.push_back({3'b110, cp[10:6]});
			3:       msg_bytes.push_back({4'b1110, cp[15:12]});
			default: msg_bytes.push_back({5'b11110, cp[20:18]});
		endcase
		for (int i = nb - 2; i >= 0; i--)
			msg_bytes.push_back({2'b10, 6'(cp >> (6 * i))});
	endfunction

	function automatic void put_scalar();
		logic [20:0] cp;
		logic [20:0] bounds[8] = '{21'h80, 21'h7FF, 21'h800, 21'hD7FF,
			21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF};
		if ($urandom_range(7) == 0) begin
			cp = bounds[$urandom_range(7)];
		end else begin
			case ($urandom_range(2))
				0: cp = 21'($urandom_range(21'h7FF, 21'h80));
				1: do cp = 21'($urandom_range(21'hFFFF, 21'h800));
					while (cp >= jubv_pkg::SURR_LO && cp <= jubv_pkg::SURR_HI);
				default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
			endcase
		end
		put_utf8(cp, (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4);
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] ch;
		do ch = 8'($urandom_range(8'h7F, 8'h20));
		while (ch == jubv_pkg::CH_QUOTE || ch == jubv_pkg::CH_BSLASH);
		return ch;
	endfunction

	// JSON-like text: whitespace and punctuation outside strings, text,
	// escapes and UTF-8 characters inside them
	function automatic void put_wellformed(input int tokens);
		logic quoted;
		quoted = 1'b0;
		for (int t = 0; t < tokens; t++) begin
			case ($urandom_range(3))
				0: if (quoted) begin
					msg_bytes.push_back(plain_char());
				end else begin
					case ($urandom_range(3))
						0:       msg_bytes.push_back(jubv_pkg::CH_TAB);
						1:       msg_bytes.push_back(jubv_pkg::CH_LF);
						2:       msg_bytes.push_back(jubv_pkg::CH_CR);
						default: msg_bytes.push_back(8'h20);
					endcase
				end
				1: put_scalar();
				2: if (quoted) begin
					msg_bytes.push_back(jubv_pkg::CH_BSLASH);
					// a multibyte character here leaves the escape open
					if ($urandom_range(3) == 0)
						put_scalar();
					msg_bytes.push_back(8'($urandom_range(8'h7F, 8'h20)));
				end else begin
					msg_bytes.push_back(plain_char());
				end
				default: begin
					msg_bytes.push_back(jubv_pkg::CH_QUOTE);
					quoted = !quoted;
				end
			endcase
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		byte_value <= b;
		last_byte  <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
		msg_bytes.delete();
	endtask

	task automatic run_phase(input int idle, input int stall, input int budget);
		int         stop_at;
		int         held;
		logic [7:0] ch;
		logic       at_end;
		idle_pct  = idle;
		stall_pct = stall;
		stop_at   = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			at_end = 1'b0;
			case ($urandom_range(19))
				0, 1, 2: begin
					repeat ($urandom_range(12, 1))
						msg_bytes.push_back(8'($urandom_range(8'hFF, 8'h00)));
				end
				3, 4, 5, 6, 7: begin
					put_wellformed($urandom_range(4));
					case ($urandom_range(5))
						0: msg_bytes.push_back(8'($urandom_range(8'h1F, 8'h00)));
						1: msg_bytes.push_back($urandom_range(1) ?
							8'($urandom_range(8'hC1, 8'h80)) : 8'($urandom_range(8'hFF, 8'hF5)));
						2: begin
							// cut a sequence short: end there or follow with a non-tail
							held = msg_bytes.size();
							put_scalar();
							repeat ($urandom_range(msg_bytes.size() - held - 1, 1))
								void'(msg_bytes.pop_back());
							if ($urandom_range(1)) begin
								at_end = 1'b1;
							end else begin
								do ch = 8'($urandom_range(8'hFF, 8'h00));
								while (ch[7:6] == 2'b10);
								msg_bytes.push_back(ch);
							end
						end
						3: if ($urandom_range(1))
							put_utf8(21'($urandom_range(21'h7FF, 21'h0)), 3);
						else
							put_utf8(21'($urandom_range(21'hFFFF, 21'h0)), 4);
						4: put_utf8(21'($urandom_range(21'hDFFF, 21'hD800)), 3);
						default: put_utf8(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
					endcase
					if (!at_end)
						put_wellformed($urandom_range(4));
				end
				default: put_wellformed($urandom_range(10, 1));
			endcase
			send_message();
		end
	endtask

	initial begin
		// assert reset just after time zero so the asynchronous clear fires
		#1 arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		msg_bytes = '{8'h00};                              send_message();
		msg_bytes = '{jubv_pkg::CH_TAB, jubv_pkg::CH_LF, jubv_pkg::CH_CR, 8'h20, 8'h7F};
		send_message();
		// the escape survives the character, so the quote stays inside
		msg_bytes = '{jubv_pkg::CH_QUOTE, jubv_pkg::CH_BSLASH, 8'hC3, 8'hA9,
			jubv_pkg::CH_QUOTE};
		send_message();
		msg_bytes = '{jubv_pkg::CH_QUOTE, jubv_pkg::CH_TAB}; send_message();
		msg_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};         send_message();
		msg_bytes = '{8'hE0, 8'h41};                       send_message();
		msg_bytes = '{8'hED, 8'hA0, 8'h80};                send_message();
		msg_bytes = '{8'hC2};                              send_message();
		msg_bytes = '{8'hFF};                              send_message();
		msg_bytes = '{8'hE0, 8'h80, 8'h80};                send_message();
		msg_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};         send_message();

		run_phase(0, 0, 485);
		run_phase(79, 0, 485);
		run_phase(0, 79, 485);
		run_phase(23, 23, 485);

		in_valid  <= 1'b0;
		stall_pct = 0;
		while (verdicts_owed != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);

		if (fail_count == 0)
			$display("json_utf8_byte_validator_top verification clean");
		else
			$display("json_utf8_byte_validator_top verification failed");
		$finish;
	end

endmodule
